@@ sv/page_replacement_lru_fifo_core_assert.svh @@
`ifndef PAGE_REPLACEMENT_LRU_FIFO_CORE_ASSERT_SVH
`define PAGE_REPLACEMENT_LRU_FIFO_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define PRLF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define PRLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/prlf_pkg.sv @@
`timescale 1ns / 1ps

package prlf_pkg;

   localparam int CSR_LIMIT_W = 5;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int FAULT_W     = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY      = 1'd1;

   localparam logic [CSR_LIMIT_W-1:0] FRAME_LIMIT_RESET = 5'd16;

   typedef enum logic {
      POLICY_LRU  = 1'b0,
      POLICY_FIFO = 1'b1
   } policy_type;

   typedef struct packed {
      logic in_use;
      logic at_tail;
      logic at_free;
      logic do_move;
      logic do_fill;
      logic force_shift;
   } cell_ctrl_type;

endpackage

@@ sv/prlf_cell.sv @@
`timescale 1ns / 1ps

module prlf_cell
   import prlf_pkg::*;
#(
   parameter int PAGE_BITS = 10
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [PAGE_BITS-1:0] ref_page,
   input  logic [PAGE_BITS-1:0] right_page,
   input  logic                 shift_in,
   output logic                 shift_out,
   output logic                 match,
   output logic [PAGE_BITS-1:0] page
);

   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] page_in;
   logic                 in_region;

   assign match     = ctrl.in_use && (page_ff == ref_page);
   assign shift_out = shift_in | match;
   assign in_region = ctrl.force_shift | shift_in | match;
   assign page      = page_ff;

   always_comb begin
      page_in = page_ff;
      if (ctrl.do_move && ctrl.at_tail) begin
         page_in = ref_page;
      end else if (ctrl.do_move && in_region && ctrl.in_use) begin
         page_in = right_page;
      end else if (ctrl.do_fill && ctrl.at_free) begin
         page_in = ref_page;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

@@ sv/page_replacement_lru_fifo_core.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_page_number
// rsp       out        rsp_valid / rsp_ready  rsp_hit, rsp_filled_free, rsp_evicted,
//                                             rsp_evicted_page, rsp_fault_total
// csr       in         csr_write_en           csr_index, csr_wdata
//
// one item per cycle while req_ready is high: every frame cell compares and shifts in the accept cycle
// result appears in the rsp register in the cycle after the item is accepted
// a stalled result holds the rsp register; req_ready drops only while it waits
// synchronous reset clears occupancy, fault count and rsp_valid, sets csr state to its defaults, no clearing pass

module page_replacement_lru_fifo_core
   import prlf_pkg::*;
#(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PAGE_BITS-1:0]   req_page_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic                   rsp_filled_free,
   output logic                   rsp_evicted,
   output logic [PAGE_BITS-1:0]   rsp_evicted_page,
   output logic [FAULT_W-1:0]     rsp_fault_total,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int OCC_W = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W = (OCC_W > CSR_LIMIT_W) ? OCC_W : CSR_LIMIT_W;

   logic [CSR_LIMIT_W-1:0] frame_limit_ff, frame_limit_in;
   policy_type             policy_ff, policy_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [FAULT_W-1:0]     fault_ff, fault_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_filled_ff, rsp_evicted_ff;
   logic [PAGE_BITS-1:0]   rsp_page_ff;
   logic [FAULT_W-1:0]     rsp_fault_ff;

   logic                   accept;
   logic                   any_hit;
   logic                   room;
   logic                   fill;
   logic                   evict;
   logic                   move;
   logic [LIM_W-1:0]       limit_ext;
   logic [LIM_W-1:0]       eff_limit;

   cell_ctrl_type          cell_ctrl  [MAX_FRAMES];
   logic [PAGE_BITS-1:0]   cell_page  [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  cell_match;
   logic [MAX_FRAMES:0]    shift_chain;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign limit_ext = LIM_W'(frame_limit_ff);
   always_comb begin
      if (frame_limit_ff == '0) begin
         eff_limit = LIM_W'(1);
      end else if (limit_ext > LIM_W'(MAX_FRAMES)) begin
         eff_limit = LIM_W'(MAX_FRAMES);
      end else begin
         eff_limit = limit_ext;
      end
   end

   assign any_hit = |cell_match;
   assign room    = LIM_W'(occ_ff) < eff_limit;
   assign fill    = !any_hit && room;
   assign evict   = !any_hit && !room;
   assign move    = (any_hit && (policy_ff == POLICY_LRU)) || evict;

   assign shift_chain[0] = 1'b0;

   for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
      logic [PAGE_BITS-1:0] right_page;

      if (k == MAX_FRAMES - 1) begin : g_last
         assign right_page = req_page_number;
      end else begin : g_inner
         assign right_page = cell_page[k+1];
      end

      assign cell_ctrl[k].in_use      = occ_ff > OCC_W'(k);
      assign cell_ctrl[k].at_tail     = occ_ff == OCC_W'(k + 1);
      assign cell_ctrl[k].at_free     = occ_ff == OCC_W'(k);
      assign cell_ctrl[k].do_move     = accept && move;
      assign cell_ctrl[k].do_fill     = accept && fill;
      assign cell_ctrl[k].force_shift = evict;

      prlf_cell #(
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[k]),
         .ref_page   (req_page_number),
         .right_page (right_page),
         .shift_in   (shift_chain[k]),
         .shift_out  (shift_chain[k+1]),
         .match      (cell_match[k]),
         .page       (cell_page[k])
      );
   end

   always_comb begin
      frame_limit_in = frame_limit_ff;
      policy_in      = policy_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_LIMIT: frame_limit_in = csr_wdata[CSR_LIMIT_W-1:0];
            CSR_POLICY:      policy_in      = policy_type'(csr_wdata[0]);
         endcase
      end
   end

   always_comb begin
      occ_in   = occ_ff;
      fault_in = fault_ff;
      if (accept && fill) begin
         occ_in = occ_ff + OCC_W'(1);
      end
      if (accept && evict && (fault_ff != '1)) begin
         fault_in = fault_ff + FAULT_W'(1);
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= FRAME_LIMIT_RESET;
         policy_ff      <= POLICY_LRU;
         occ_ff         <= '0;
         fault_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         frame_limit_ff <= frame_limit_in;
         policy_ff      <= policy_in;
         occ_ff         <= occ_in;
         fault_ff       <= fault_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff     <= any_hit;
         rsp_filled_ff  <= fill;
         rsp_evicted_ff <= evict;
         rsp_page_ff    <= evict ? cell_page[0] : '0;
         rsp_fault_ff   <= fault_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_filled_free  = rsp_filled_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_page_ff;
   assign rsp_fault_total  = rsp_fault_ff;

endmodule

@@ sv/prlf_checker.sv @@
`timescale 1ns / 1ps
`include "page_replacement_lru_fifo_core_assert.svh"

module prlf_checker #(
   parameter int PAGE_BITS = 10,
   parameter int FAULT_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_hit,
   input logic                  rsp_filled_free,
   input logic                  rsp_evicted,
   input logic [PAGE_BITS-1:0]  rsp_evicted_page,
   input logic [FAULT_BITS-1:0] rsp_fault_total
);

   `PRLF_ASSERT_NOW(a_one_outcome, clock, reset, rsp_valid, $onehot({rsp_hit, rsp_filled_free, rsp_evicted}))

   `PRLF_ASSERT_NOW(a_no_victim_page, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_page == '0)

   `PRLF_ASSERT_NOW(a_fault_counted, clock, reset, rsp_valid && rsp_evicted, rsp_fault_total != '0)

   `PRLF_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fault_total))

endmodule

bind page_replacement_lru_fifo_core prlf_checker #(
   .PAGE_BITS  (PAGE_BITS),
   .FAULT_BITS (32)
) u_prlf_checker (.*);

@@ sim/prlf_reference_check.sv @@
`timescale 1ns / 1ps

module prlf_reference_check
   import prlf_pkg::*;
#(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [PAGE_BITS-1:0]   req_page_number,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_hit,
   input  logic                   rsp_filled_free,
   input  logic                   rsp_evicted,
   input  logic [PAGE_BITS-1:0]   rsp_evicted_page,
   input  logic [FAULT_W-1:0]     rsp_fault_total,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            mismatch_count,
   output int unsigned            results_owed
);

   typedef struct packed {
      logic                 hit;
      logic                 filled_free;
      logic                 evicted;
      logic [PAGE_BITS-1:0] evicted_page;
      logic [FAULT_W-1:0]   fault_total;
   } page_outcome_type;

   logic [PAGE_BITS-1:0]   frame_page [MAX_FRAMES];
   int                     frames_used;
   logic [FAULT_W-1:0]     fault_count;
   logic [CSR_LIMIT_W-1:0] limit_setting;
   policy_type             policy_setting;
   page_outcome_type       outcome_q [$];
   int unsigned            mismatches;

   assign mismatch_count = mismatches;

   // drop one slot and pull the newer pages down by one
   function automatic void close_gap(input int from);
      int k;
      for (k = from; k + 1 < frames_used; k++) begin
         frame_page[k] = frame_page[k + 1];
      end
   endfunction

   function automatic page_outcome_type reference_page(input logic [PAGE_BITS-1:0] page);
      page_outcome_type r;
      int               cap;
      int               slot;
      int               k;
      r    = '0;
      slot = -1;
      if (limit_setting == 0) begin
         cap = 1;
      end else if (limit_setting > MAX_FRAMES) begin
         cap = MAX_FRAMES;
      end else begin
         cap = limit_setting;
      end
      for (k = 0; k < frames_used; k++) begin
         if (slot < 0 && frame_page[k] == page) begin
            slot = k;
         end
      end
      if (slot >= 0) begin
         r.hit = 1'b1;
         if (policy_setting == POLICY_LRU) begin
            close_gap(slot);
            frame_page[frames_used - 1] = page;
         end
      end else if (frames_used < cap) begin
         r.filled_free = 1'b1;
         frame_page[frames_used] = page;
         frames_used++;
      end else begin
         r.evicted      = 1'b1;
         r.evicted_page = frame_page[0];
         close_gap(0);
         frame_page[frames_used - 1] = page;
         if (fault_count != '1) begin
            fault_count++;
         end
      end
      r.fault_total = fault_count;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [FAULT_W-1:0] want,
                                input logic [FAULT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      page_outcome_type want;
      if (reset) begin
         frames_used    = 0;
         fault_count    = '0;
         limit_setting  = FRAME_LIMIT_RESET;
         policy_setting = POLICY_LRU;
         outcome_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_FRAME_LIMIT) begin
               limit_setting = csr_wdata[CSR_LIMIT_W-1:0];
            end else if (csr_index == CSR_POLICY) begin
               policy_setting = policy_type'(csr_wdata[0]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result item: hit %0b fill %0b evict %0b page %0d",
                           rsp_hit, rsp_filled_free, rsp_evicted, rsp_evicted_page);
               end
            end else begin
               want = outcome_q.pop_front();
               compare_field("hit", FAULT_W'(want.hit), FAULT_W'(rsp_hit));
               compare_field("filled_free", FAULT_W'(want.filled_free),
                             FAULT_W'(rsp_filled_free));
               compare_field("evicted", FAULT_W'(want.evicted), FAULT_W'(rsp_evicted));
               compare_field("evicted_page", FAULT_W'(want.evicted_page),
                             FAULT_W'(rsp_evicted_page));
               compare_field("fault_total", want.fault_total, rsp_fault_total);
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(reference_page(req_page_number));
         end
      end
      results_owed <= outcome_q.size();
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import prlf_pkg::*;

   localparam int MAX_FRAMES = 16;
   localparam int PAGE_BITS  = 10;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [PAGE_BITS-1:0]   req_page_number;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_hit;
   logic                   rsp_filled_free;
   logic                   rsp_evicted;
   logic [PAGE_BITS-1:0]   rsp_evicted_page;
   logic [FAULT_W-1:0]     rsp_fault_total;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int unsigned mismatch_total;
   int unsigned results_owed;
   int          items_sent;
   int          stall_left;
   logic        quiet;

   page_replacement_lru_fifo_core #(
      .MAX_FRAMES(MAX_FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_filled_free (rsp_filled_free),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_page(rsp_evicted_page),
      .rsp_fault_total (rsp_fault_total),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   prlf_reference_check #(
      .MAX_FRAMES(MAX_FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_filled_free (rsp_filled_free),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_page(rsp_evicted_page),
      .rsp_fault_total (rsp_fault_total),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_total),
      .results_owed    (results_owed)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_page(input logic [PAGE_BITS-1:0] page);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [PAGE_BITS-1:0]   pool [20];
      logic [CSR_LIMIT_W-1:0] limit;
      int                     cap;
      int                     pool_size;
      int                     k;
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_page_number = '0;
      rsp_ready       = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = CSR_FRAME_LIMIT;
      csr_wdata       = '0;
      stall_left      = 0;
      quiet           = 1'b0;
      items_sent      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // four frames, lru: fill, hit moves page, evictions
      write_csr(CSR_FRAME_LIMIT, 5'd4);
      send_page(10'd0);
      send_page(10'd1023);
      send_page(10'h2aa);
      send_page(10'h155);
      send_page(10'd0);
      send_page(10'd7);
      send_page(10'h155);
      send_page(10'd8);
      // fifo: hit leaves order alone
      write_csr(CSR_POLICY, 5'd1);
      send_page(10'd0);
      send_page(10'd9);
      // zero limit acts as one frame, occupancy stays above it
      write_csr(CSR_FRAME_LIMIT, 5'd0);
      send_page(10'd1023);
      send_page(10'd5);
      // limit above depth saturates, back to lru with upper data bits set
      write_csr(CSR_FRAME_LIMIT, 5'd31);
      write_csr(CSR_POLICY, 5'd30);
      send_page(10'd11);
      send_page(10'd12);
      send_page(10'd1023);
      write_csr(CSR_FRAME_LIMIT, 5'd17);
      send_page(10'd13);

      while (items_sent < 820) begin
         case ($urandom_range(0, 7))
            0:       limit = 5'd0;
            1:       limit = 5'd1;
            2:       limit = 5'd16;
            3:       limit = 5'd31;
            4:       limit = 5'd17;
            default: limit = 5'($urandom_range(1, 16));
         endcase
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1) begin
            write_csr(CSR_FRAME_LIMIT, limit);
            write_csr(CSR_POLICY, 5'($urandom_range(0, 31)));
         end else begin
            write_csr(CSR_POLICY, 5'($urandom_range(0, 31)));
            write_csr(CSR_FRAME_LIMIT, limit);
         end
         if (limit == 0) begin
            cap = 1;
         end else if (limit > MAX_FRAMES) begin
            cap = MAX_FRAMES;
         end else begin
            cap = limit;
         end
         pool_size = cap + $urandom_range(0, 4);
         for (k = 0; k < pool_size; k++) begin
            pool[k] = 10'($urandom_range(0, 1023));
         end
         repeat ($urandom_range(30, 70)) begin
            if ($urandom_range(0, 99) < 85) begin
               send_page(pool[$urandom_range(0, pool_size - 1)]);
            end else begin
               send_page(10'($urandom_range(0, 1023)));
            end
            if ($urandom_range(0, 199) == 0) begin
               wait_idle();
            end
         end
      end

      wait_idle();
      repeat (5) @(posedge clock);
      if (mismatch_total == 0 && results_owed == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ page_replacement_lru_fifo_core.f @@
+incdir+sv
sv/prlf_pkg.sv
sv/prlf_cell.sv
sv/page_replacement_lru_fifo_core.sv
sv/prlf_checker.sv
sim/prlf_reference_check.sv
sim/testbench.sv
